>>> sv/shsk_pkg.sv
// ----------------------------------------------------------------------------
// shsk_pkg - shared definitions for the shuffle sampler
// Constants, controller states and the command and status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package shsk_pkg;

    localparam int DEPTH_DEFAULT   = 4096;
    localparam int ID_BITS_DEFAULT = 24;

    localparam int RND_W    = 31;
    localparam int SEED_W   = 7;
    localparam int MAX_OUT  = 64;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int STEP_W   = $clog2(RND_W);

    localparam logic [SEED_W-1:0] SEED_COUNT_RESET = SEED_W'(10);

    // register index, taken from the word address
    localparam logic REG_SEED_COUNT = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_READ,
        S_MOVE,
        S_PLACE,
        S_FINISH,
        S_EMIT_RD,
        S_EMIT_LOAD
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic div_step;
        logic rd_pos;
        logic move;
        logic place;
        logic emit_setup;
        logic emit_rd;
        logic emit_load;
        logic clear_count;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic div_last;
        logic pos_eq_count;
        logic last_item;
        logic emit_done;
        logic out_free;
    } status_t;

endpackage

>>> sv/shsk_ram.sv
// ----------------------------------------------------------------------------
// shsk_ram - generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module shsk_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/shsk_ctrl.sv
// ----------------------------------------------------------------------------
// shsk_ctrl - sequencing controller
// Steps each word through divide, swap, place and the seed emission.
// ----------------------------------------------------------------------------
module shsk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  shsk_pkg::status_t st,
    output shsk_pkg::cmd_t    cmd
);

    shsk_pkg::state_t state_reg;
    shsk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= shsk_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        case (state_reg)
            shsk_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = shsk_pkg::S_DIVIDE;
                end
            end
            shsk_pkg::S_DIVIDE:
            begin
                // a full store drops the candidate but keeps its last mark
                if (st.full)
                begin
                    state_next = shsk_pkg::S_FINISH;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (st.div_last)
                    begin
                        state_next = shsk_pkg::S_READ;
                    end
                end
            end
            shsk_pkg::S_READ:
            begin
                if (st.pos_eq_count)
                begin
                    state_next = shsk_pkg::S_PLACE;
                end
                else
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = shsk_pkg::S_MOVE;
                end
            end
            shsk_pkg::S_MOVE:
            begin
                cmd.move   = 1'b1;
                state_next = shsk_pkg::S_PLACE;
            end
            shsk_pkg::S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = shsk_pkg::S_FINISH;
            end
            shsk_pkg::S_FINISH:
            begin
                if (st.last_item)
                begin
                    cmd.emit_setup = 1'b1;
                    state_next     = shsk_pkg::S_EMIT_RD;
                end
                else
                begin
                    state_next = shsk_pkg::S_IDLE;
                end
            end
            shsk_pkg::S_EMIT_RD:
            begin
                if (st.emit_done)
                begin
                    cmd.clear_count = 1'b1;
                    state_next      = shsk_pkg::S_IDLE;
                end
                else
                begin
                    cmd.emit_rd = 1'b1;
                    state_next  = shsk_pkg::S_EMIT_LOAD;
                end
            end
            shsk_pkg::S_EMIT_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = shsk_pkg::S_EMIT_RD;
                end
            end
            default:
            begin
                state_next = shsk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/shsk_datapath.sv
// ----------------------------------------------------------------------------
// shsk_datapath - serial remainder, candidate store and output register
// Holds the count, the seed_count register and the store address muxing.
// ----------------------------------------------------------------------------
module shsk_datapath #(
    parameter int DEPTH   = shsk_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = shsk_pkg::ID_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shsk_pkg::cmd_t                cmd,
    output shsk_pkg::status_t             st,
    input  logic [ID_BITS-1:0]            node_id,
    input  logic [shsk_pkg::RND_W-1:0]    random_word,
    input  logic                          last_item,
    output logic                          seed_valid,
    input  logic                          seed_ready,
    output logic [ID_BITS-1:0]            seed_id,
    output logic                          last_seed,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shsk_pkg::PADDR_W-1:0]  paddr,
    input  logic [shsk_pkg::PDATA_W-1:0]  pwdata,
    output logic [shsk_pkg::PDATA_W-1:0]  prdata
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MW     = (CNT_W > shsk_pkg::SEED_W) ? CNT_W : shsk_pkg::SEED_W;
    localparam int SW     = shsk_pkg::SEED_W;

    // payload held for the current word
    logic [ID_BITS-1:0]          id_reg;
    logic [shsk_pkg::RND_W-1:0]  rnd_reg;
    logic [shsk_pkg::RND_W-1:0]  rnd_next;
    logic                        last_reg;

    // control state
    logic [CNT_W-1:0]            count_reg,  count_next;
    logic [CNT_W-1:0]            rem_reg,    rem_next;
    logic [shsk_pkg::STEP_W-1:0] step_reg,   step_next;
    logic [SW-1:0]               seed_reg,   seed_next;
    logic [SW-1:0]               total_reg,  total_next;
    logic [SW-1:0]               idx_reg,    idx_next;
    logic                        ovalid_reg, ovalid_next;
    logic [ID_BITS-1:0]          oid_reg;
    logic                        olast_reg;

    logic [CNT_W:0]              divisor;
    logic [CNT_W:0]              trial;
    logic [ADDR_W-1:0]           pos;
    logic [MW-1:0]               min_a;
    logic [MW-1:0]               min_b;
    logic                        cfg_wr;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ID_BITS-1:0]          ram_wdata;
    logic                        ram_re;
    logic [ADDR_W-1:0]           ram_raddr;
    logic [ID_BITS-1:0]          ram_rdata;

    assign divisor = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign trial   = {rem_reg, rnd_reg[shsk_pkg::RND_W-1]};
    assign pos     = ADDR_W'(rem_reg);
    assign cfg_wr  = psel && penable && pwrite && (paddr[2] == shsk_pkg::REG_SEED_COUNT);

    // emission length: min(seed_count, count, MAX_OUT)
    always_comb
    begin
        min_a = (MW'(seed_reg) < MW'(count_reg)) ? MW'(seed_reg) : MW'(count_reg);
        min_b = (min_a < MW'(shsk_pkg::MAX_OUT)) ? min_a : MW'(shsk_pkg::MAX_OUT);
    end

    always_comb
    begin
        rem_next    = rem_reg;
        rnd_next    = rnd_reg;
        step_next   = step_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        seed_next   = seed_reg;
        ovalid_next = ovalid_reg;

        if (cmd.latch_in)
        begin
            rem_next  = '0;
            rnd_next  = random_word;
            step_next = '0;
        end
        if (cmd.div_step)
        begin
            // one restoring step per cycle, dividend MSB first
            rem_next  = (trial >= divisor) ? CNT_W'(trial - divisor) : CNT_W'(trial);
            rnd_next  = {rnd_reg[shsk_pkg::RND_W-2:0], 1'b0};
            step_next = step_reg + shsk_pkg::STEP_W'(1);
        end
        if (cmd.place)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        if (cmd.emit_setup)
        begin
            total_next = SW'(min_b);
            idx_next   = '0;
        end
        if (cmd.emit_load)
        begin
            idx_next = idx_reg + SW'(1);
        end
        if (cfg_wr)
        begin
            seed_next = pwdata[SW-1:0];
        end
        if (cmd.emit_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (seed_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            rem_reg    <= '0;
            step_reg   <= '0;
            seed_reg   <= shsk_pkg::SEED_COUNT_RESET;
            total_reg  <= '0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rem_reg    <= rem_next;
            step_reg   <= step_next;
            seed_reg   <= seed_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg <= rnd_next;
        if (cmd.latch_in)
        begin
            id_reg   <= node_id;
            last_reg <= last_item;
        end
        if (cmd.emit_load)
        begin
            oid_reg   <= ram_rdata;
            olast_reg <= (SW'(idx_reg + SW'(1)) == total_reg);
        end
    end

    // store port muxing
    always_comb
    begin
        ram_we    = cmd.move || cmd.place;
        ram_waddr = cmd.move ? ADDR_W'(count_reg) : pos;
        ram_wdata = cmd.move ? ram_rdata : id_reg;
        ram_re    = cmd.rd_pos || cmd.emit_rd;
        ram_raddr = cmd.rd_pos ? pos : ADDR_W'(idx_reg);
    end

    shsk_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        st.full         = (count_reg == CNT_W'(DEPTH));
        st.div_last     = (step_reg == shsk_pkg::STEP_W'(shsk_pkg::RND_W - 1));
        st.pos_eq_count = (rem_reg == count_reg);
        st.last_item    = last_reg;
        st.emit_done    = (idx_reg == total_reg);
        st.out_free     = !ovalid_reg || seed_ready;
    end

    assign seed_valid = ovalid_reg;
    assign seed_id    = oid_reg;
    assign last_seed  = olast_reg;
    assign prdata     = (paddr[2] == shsk_pkg::REG_SEED_COUNT) ?
                        shsk_pkg::PDATA_W'(seed_reg) : '0;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("candidate count beyond store depth");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_pos |-> (rem_reg < count_reg))
        else $error("placement position outside the filled store");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (idx_reg < total_reg))
        else $error("emission load past the clamped length");

endmodule

>>> sv/shuffle_sample_first_k_top.sv
// ----------------------------------------------------------------------------
// shuffle_sample_first_k_top - inside-out shuffle sampler
// Builds a random permutation of incoming candidate ids and emits the first
// seed_count of them, at most 64, when the last candidate of a set arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_ready) carries node_id, random_word and
//   last_item. Each word is placed at random_word mod (count+1); the entry
//   displaced from there moves to the end of the store. Words beyond DEPTH
//   are dropped, but their last_item mark still triggers emission.
//   Output channel (seed_valid/seed_ready) carries seed_id and last_seed;
//   after a last word, min(seed_count, count, 64) ids leave in store order,
//   last_seed marking the final one, and the count returns to zero.
//   A word passes through accept, 31 serial remainder steps, one read,
//   one move, one place and one finish; nothing is read or moved when it
//   lands at the end, and a full store goes from the divide state straight
//   to finish. The remainder steps take the 31-bit random word MSB first.
//   Emission reads each id and loads it into the output register once that
//   is free; a last read step closes the run.
//   Reset clears the count and loads seed_count with 10; store contents are
//   left as they were and are never read before being written in a run.
//   A stalled receiver holds the output register; emission waits, and
//   item_ready stays low until the run is closed. A new word is taken while
//   the final id still waits.
//   seed_count sits at APB byte address 0; pready is always high.
// ----------------------------------------------------------------------------
module shuffle_sample_first_k_top #(
    parameter int DEPTH   = shsk_pkg::DEPTH_DEFAULT,
    parameter int ID_BITS = shsk_pkg::ID_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // candidate words
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [ID_BITS-1:0]            node_id,
    input  logic [shsk_pkg::RND_W-1:0]    random_word,
    input  logic                          last_item,
    // sampled ids
    output logic                          seed_valid,
    input  logic                          seed_ready,
    output logic [ID_BITS-1:0]            seed_id,
    output logic                          last_seed,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shsk_pkg::PADDR_W-1:0]  paddr,
    input  logic [shsk_pkg::PDATA_W-1:0]  pwdata,
    output logic [shsk_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    shsk_pkg::cmd_t    cmd;
    shsk_pkg::status_t st;

    // never stall the bus
    assign pready = 1'b1;

    // sequence each word: divide, swap, place, then emit on a last word
    shsk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    // hold the store, the remainder unit and the output register
    shsk_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .node_id     (node_id),
        .random_word (random_word),
        .last_item   (last_item),
        .seed_valid  (seed_valid),
        .seed_ready  (seed_ready),
        .seed_id     (seed_id),
        .last_seed   (last_seed),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata)
    );

endmodule
